>>> sv/trd_pkg.sv
package trd_pkg;
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_DRAW    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [0:0] REG_WIDTH  = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  localparam logic [16:0] CountMax = 17'h1FFFF;

  // shared multiplier request between sequencer and unit
  typedef struct packed {
    logic signed [25:0] a;
    logic signed [25:0] b;
  } mul_req_t;
endpackage

>>> sv/trd_mul.sv
module trd_mul
  import trd_pkg::*;
(
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [51:0] prod
);
  logic signed [51:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;
endmodule

>>> sv/trd_div.sv
module trd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [51:0] num,
  input  logic [29:0]        den,
  output logic               done,
  output logic signed [51:0] quo
);
  // restoring division on magnitude, floor fixup for negative numerator
  logic [51:0] q_r, q_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [29:0] den_r;
  logic [30:0] trial;
  logic        nz;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r[29:0], q_r[51]};
    nz       = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd52;
      neg_nxt  = num[51];
      q_nxt    = num[51] ? 52'(-num) : 52'(num);
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[50:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[50:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    nz = rem_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = neg_r ? (nz ? -$signed(q_r) - 52'sd1 : -$signed(q_r)) : $signed(q_r);
endmodule

>>> sv/triangle_raster_depth_test.sv
// out_valid follows a read, an unknown op, a clear over MAX_WIDTH*MAX_HEIGHT entries (one
// entry a cycle), or a draw that walks the bounding box, with each covered pixel going
// through the serial divider
// throughput: one word at a time, in_stall high while busy or while the result waits
// reset runs the same clearing pass before the first word, with no result word;
// sizes reset to 256
module triangle_raster_depth_test
  import trd_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_ax,
  input  logic [11:0] in_ay,
  input  logic signed [15:0] in_az,
  input  logic [11:0] in_bx,
  input  logic [11:0] in_by_row,
  input  logic signed [15:0] in_bz,
  input  logic [11:0] in_cx,
  input  logic [11:0] in_cy,
  input  logic signed [15:0] in_cz,
  input  logic [7:0]  in_fill_color,
  input  logic [15:0] in_pixel_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_pixels_written,
  output logic [7:0]  out_pixel_color,
  output logic signed [15:0] out_pixel_depth,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int Size = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(Size);
  localparam int XW   = $clog2(MAX_WIDTH + 1);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_RD0  = 5'd2,
                         S_RD1  = 5'd3,  S_D0   = 5'd4,  S_D1   = 5'd5,
                         S_D2   = 5'd6,  S_PIX  = 5'd7,  S_M0   = 5'd8,
                         S_M1   = 5'd9,  S_M2   = 5'd10, S_M3   = 5'd11,
                         S_M4   = 5'd12, S_M5   = 5'd13, S_DIV  = 5'd14,
                         S_MRD  = 5'd15, S_CMP  = 5'd16, S_NEXT = 5'd17,
                         S_OUT  = 5'd18, S_W0   = 5'd19, S_W1   = 5'd20,
                         S_W2   = 5'd21;

  logic [4:0] st_r, st_nxt;
  logic [8:0] aw_r, ah_r;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic init_r;

  // config
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= 9'd256;
      ah_r <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) aw_r <= pwdata[8:0];
      else                       ah_r <= pwdata[8:0];
    end
  end
  assign prdata = {23'd0, (paddr[2] == REG_HEIGHT) ? ah_r : aw_r};

  always_comb begin
    if (aw_r == 9'd0) w_eff = XW'(1);
    else if ({23'd0, aw_r} > 32'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(aw_r);
    if (ah_r == 9'd0) h_eff = YW'(1);
    else if ({23'd0, ah_r} > 32'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(ah_r);
  end

  // latched item
  logic [12:0] x0_r, y0_r;
  logic signed [15:0] z0_r, z1_r, z2_r;
  logic [7:0] col_r;
  logic [15:0] pidx_r;
  logic signed [12:0] abx_r, aby_r, acx_r, acy_r;
  logic [11:0] mnx_r, mny_r, mxx_r, mxy_r;
  logic signed [25:0] d_r;
  logic signed [51:0] s_r, t_r, u_r, num_r;
  logic signed [15:0] q_r;
  logic [9:0] px_r, py_r, lx_r, ly_r, hx_r, hy_r;
  logic [16:0] cnt_r;
  logic [AW:0] cidx_r;
  logic [16:0] ow_r;
  logic [7:0] oc_r;
  logic signed [15:0] od_r;
  logic ov_r;

  // shared multiplier
  mul_req_t mreq;
  logic signed [51:0] prod;
  trd_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  logic signed [14:0] apx, apy;
  assign apx = 15'($signed({1'b0, px_r, 4'd8})) - 15'($signed({2'b0, x0_r[11:0]}));
  assign apy = 15'($signed({1'b0, py_r, 4'd8})) - 15'($signed({2'b0, y0_r[11:0]}));

  // kept weights lie within the doubled area, so 26 bits carry them
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (st_r)
      S_D0: begin mreq.a = 26'(abx_r); mreq.b = 26'(acy_r); end
      S_D1: begin mreq.a = 26'(aby_r); mreq.b = 26'(acx_r); end
      S_PIX: begin mreq.a = 26'(acy_r); mreq.b = 26'(apx); end
      S_M0: begin mreq.a = 26'(acx_r); mreq.b = 26'(apy); end
      S_M1: begin mreq.a = 26'(abx_r); mreq.b = 26'(apy); end
      S_M2: begin mreq.a = 26'(aby_r); mreq.b = 26'(apx); end
      S_M4: begin mreq.a = 26'(s_r); mreq.b = 26'(z1_r); end
      S_M5: begin mreq.a = 26'(t_r); mreq.b = 26'(z2_r); end
      S_W0: begin mreq.a = 26'(u_r); mreq.b = 26'(z0_r); end
      default: ;
    endcase
  end

  // memory
  logic [AW-1:0] maddr;
  logic          mwe;
  logic [23:0]   mwd, mrd_r;
  logic [23:0]   mem [Size];
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd_r <= mem[maddr];
  end

  logic [19:0] pix_lin;
  assign pix_lin = 20'(py_r) * 20'(w_eff) + 20'(px_r);

  // floor divider, weights times depths go through the multiplier too
  logic div_start, div_done;
  logic signed [51:0] div_q;
  logic [29:0] dabs;
  assign dabs = d_r[25] ? 30'(-d_r) : 30'(d_r);
  trd_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
                 .num(d_r[25] ? -num_r : num_r), .den(dabs),
                 .done(div_done), .quo(div_q));

  logic sgn_ok;
  always_comb begin
    if (d_r > 0) sgn_ok = !u_r[51] && !s_r[51] && !t_r[51];
    else sgn_ok = (u_r <= 0) && (s_r <= 0) && (t_r <= 0);
  end

  logic [12:0] ax13, ay13, bx13, by13, cx13, cy13;
  assign ax13 = {1'b0, in_ax}; assign ay13 = {1'b0, in_ay};
  assign bx13 = {1'b0, in_bx}; assign by13 = {1'b0, in_by_row};
  assign cx13 = {1'b0, in_cx}; assign cy13 = {1'b0, in_cy};

  logic [11:0] mn_x, mn_y, mx_x, mx_y;
  always_comb begin
    mn_x = in_ax < in_bx ? in_ax : in_bx; if (in_cx < mn_x) mn_x = in_cx;
    mx_x = in_ax > in_bx ? in_ax : in_bx; if (in_cx > mx_x) mx_x = in_cx;
    mn_y = in_ay < in_by_row ? in_ay : in_by_row; if (in_cy < mn_y) mn_y = in_cy;
    mx_y = in_ay > in_by_row ? in_ay : in_by_row; if (in_cy > mx_y) mx_y = in_cy;
  end

  logic [9:0] hxc, hyc;
  always_comb begin
    hxc = 10'((13'(mxx_r) + 13'd15) >> 4);
    if (hxc > 10'(w_eff - XW'(1))) hxc = 10'(w_eff - XW'(1));
    hyc = 10'((13'(mxy_r) + 13'd15) >> 4);
    if (hyc > 10'(h_eff - YW'(1))) hyc = 10'(h_eff - YW'(1));
  end

  logic accept;
  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign accept   = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_pixels_written = ow_r;
  assign out_pixel_color = oc_r;
  assign out_pixel_depth = od_r;

  always_comb begin
    st_nxt    = st_r;
    maddr     = AW'(pix_lin);
    mwe       = 1'b0;
    mwd       = {q_r, col_r};
    div_start = 1'b0;
    case (st_r)
      S_IDLE: if (accept) begin
        case (in_op)
          OP_CLEAR: st_nxt = S_CLR;
          OP_DRAW:  st_nxt = S_D0;
          OP_READ:  st_nxt = S_RD0;
          default:  st_nxt = S_OUT;
        endcase
      end
      S_CLR: begin
        maddr = cidx_r[AW-1:0];
        mwe   = 1'b1;
        mwd   = '0;
        // the pass after reset returns no word
        if (cidx_r == (AW+1)'(Size - 1)) st_nxt = init_r ? S_IDLE : S_OUT;
      end
      S_RD0: begin
        maddr = pidx_r[AW-1:0];
        st_nxt = S_RD1;
      end
      S_RD1: st_nxt = S_OUT;
      S_D0: st_nxt = S_D1;
      S_D1: st_nxt = S_D2;
      S_D2: begin
        // zero area or a box fully off screen draws nothing
        if (d_r == 26'(prod) || hxc < 10'(mnx_r >> 4) || hyc < 10'(mny_r >> 4))
          st_nxt = S_OUT;
        else st_nxt = S_PIX;
      end
      S_PIX: st_nxt = S_M0;
      S_M0: st_nxt = S_M1;
      S_M1: st_nxt = S_M2;
      S_M2: st_nxt = S_M3;
      S_M3: st_nxt = S_M4;
      S_M4: st_nxt = S_M5;
      S_M5: st_nxt = sgn_ok ? S_W0 : S_NEXT;
      S_W0: st_nxt = S_W1;
      S_W1: st_nxt = S_W2;
      S_W2: begin
        div_start = 1'b1;
        st_nxt = S_DIV;
      end
      S_DIV: if (div_done) st_nxt = S_MRD;
      S_MRD: st_nxt = S_CMP;
      S_CMP: begin
        mwe = q_r >= $signed(mrd_r[23:8]);
        st_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (py_r == hy_r && px_r == hx_r) st_nxt = S_OUT;
        else st_nxt = S_PIX;
      end
      S_OUT: if (!ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      cidx_r <= '0;
      ov_r   <= 1'b0;
      init_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) cidx_r <= cidx_r + 1'b1;
      else cidx_r <= '0;
      if (st_r != S_CLR) init_r <= 1'b0;
      if (out_valid && !out_stall) ov_r <= 1'b0;
      if (st_r == S_OUT && !ov_r) ov_r <= 1'b1;
    end
    if (accept) begin
      x0_r <= ax13; y0_r <= ay13;
      z0_r <= in_az; z1_r <= in_bz; z2_r <= in_cz;
      col_r <= in_fill_color; pidx_r <= in_pixel_index;
      abx_r <= $signed(bx13 - ax13); aby_r <= $signed(by13 - ay13);
      acx_r <= $signed(cx13 - ax13); acy_r <= $signed(cy13 - ay13);
      mnx_r <= mn_x; mny_r <= mn_y; mxx_r <= mx_x; mxy_r <= mx_y;
      cnt_r <= '0;
      ow_r <= '0; oc_r <= '0; od_r <= '0;
      d_r <= '0;
    end
    case (st_r)
      S_D1: d_r <= 26'(prod);
      S_D2: begin
        d_r  <= d_r - 26'(prod);
        lx_r <= 10'(mnx_r >> 4); ly_r <= 10'(mny_r >> 4);
        px_r <= 10'(mnx_r >> 4); py_r <= 10'(mny_r >> 4);
        hx_r <= hxc; hy_r <= hyc;
      end
      S_M0: s_r <= prod;
      S_M1: s_r <= s_r - prod;
      S_M2: t_r <= prod;
      S_M3: begin t_r <= t_r - prod; end
      S_M4: u_r <= 52'(d_r) - s_r - t_r;
      // depth sum: one product per cycle off the shared multiplier
      S_M5: num_r <= prod;
      S_W0: num_r <= num_r + prod;
      S_W1: num_r <= num_r + prod;
      S_DIV: if (div_done) q_r <= 16'(div_q);
      S_CMP: if (q_r >= $signed(mrd_r[23:8]) && cnt_r != CountMax) cnt_r <= cnt_r + 17'd1;
      S_NEXT: begin
        if (py_r == hy_r) begin
          py_r <= ly_r;
          px_r <= px_r + 10'd1;
        end else py_r <= py_r + 10'd1;
      end
      S_RD1: if ({16'd0, pidx_r} < 32'(Size)) begin
        oc_r <= mrd_r[7:0];
        od_r <= $signed(mrd_r[23:8]);
      end
      S_OUT: ow_r <= cnt_r;
      default: ;
    endcase
  end
endmodule
